// File: hdl/voxel_ray_traversal_top_assert.svh
// Assertion macros for the voxel ray traversal top level.
// Used by voxel_ray_traversal_top.sv; expects clk and rst_n in scope.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH

// same-cycle implication
`define VRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vrt_pkg.sv
// Package for the voxel ray traversal block: grid size, step limit, item types.
// No dependencies.
package vrt_pkg;

  localparam int WORLD_SIDE   = 64;
  localparam int WORLD_HEIGHT = 64;
  localparam int MAX_STEPS    = 256;

  localparam int STORE_DEPTH = WORLD_SIDE * WORLD_HEIGHT * WORLD_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CRD_W       = $clog2((WORLD_SIDE > WORLD_HEIGHT) ? WORLD_SIDE : WORLD_HEIGHT);
  localparam int STEP_W      = $clog2(MAX_STEPS + 1);
  localparam int CELL_W      = 18;

  localparam logic [30:0] DIST_MAX   = 31'h7FFF_FFFF;
  localparam logic [32:0] START_BIAS = 33'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         voxel_x;
    logic [5:0]         voxel_y;
    logic [5:0]         voxel_z;
    logic [7:0]         block_id;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        range_limit;
  } vrt_in_t;

  typedef struct packed {
    logic [7:0]         found_block;
    logic [30:0]        hit_distance;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic signed [15:0] hit_z;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] prev_z;
  } vrt_out_t;

endpackage

// File: hdl/vrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/voxel_ray_traversal_top.sv
// Voxel ray traversal: voxel store plus a 3D DDA ray caster over it.
// Depends on vrt_pkg, vrt_ram and voxel_ray_traversal_top_assert.svh.
//
//   channel | ports                          | moves
//   input   | in_valid, in_stall, in_item    | write or cast item
//   output  | out_valid, out_stall, out_item | one result item per cast
//
// A write item is written to the store from the idle state. A cast is accepted, then
// goes through squaring, square root, a reciprocal division per nonzero direction
// component (none for a zero one), crossing setup, then one store read per voxel
// visited, and last hands over the result.
// After reset a clearing pass zeroes all STORE_DEPTH (262144) entries of the store;
// no item is taken meanwhile. A result held by out_stall stalls only the next cast.
module voxel_ray_traversal_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrt_pkg::vrt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output vrt_pkg::vrt_out_t out_item
);
  import vrt_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SQM, S_SQA, S_SQRT, S_DINIT, S_DIV,
    S_XMUL, S_XSAT, S_RD, S_CHK, S_DONE
  } state_t;

  state_t                    state_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic [1:0]                ax_r;
  logic [31:0]               mag_r   [3];
  logic                      neg_r   [3];
  logic                      zero_r  [3];
  logic [15:0]               frac_r  [3];
  logic signed [CELL_W-1:0]  cell_r  [3];
  logic signed [CELL_W-1:0]  prev_r  [3];
  logic [30:0]               stepd_r [3];
  logic [30:0]               next_r  [3];
  logic [63:0]               acc_r;
  logic [63:0]               prod_r;
  logic [63:0]               root_r;
  logic [63:0]               bit_r;
  logic [5:0]                iter_r;
  logic [31:0]               len_r;
  logic [31:0]               div_rem_r;
  logic [47:0]               div_q_r;
  logic [30:0]               last_r;
  logic [30:0]               range_r;
  logic [STEP_W-1:0]         cnt_r;
  logic                      out_valid_r;
  vrt_out_t                  out_item_r;

  logic [31:0]               st_in  [3];
  logic [31:0]               dir_in [3];
  logic [31:0]               sb     [3];
  logic [31:0]               mag_in [3];
  logic [32:0]               s33;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               mul_p;
  logic [16:0]               f_init;
  logic [63:0]               sq_t;
  logic                      sq_ge;
  logic [32:0]               trial;
  logic                      div_ge;
  logic [1:0]                a_sel;
  logic [31:0]               sum32;
  logic [30:0]               nadd;
  logic                      in_grid;
  logic [7:0]                hit_v;
  logic                      stop;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [7:0]                ram_wdata, ram_rdata;
  logic                      wr_inside;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    st_in[0]  = in_item.start_x;
    st_in[1]  = in_item.start_y;
    st_in[2]  = in_item.start_z;
    dir_in[0] = in_item.dir_x;
    dir_in[1] = in_item.dir_y;
    dir_in[2] = in_item.dir_z;
    s33 = '0;
    for (int i = 0; i < 3; i++) begin
      s33       = {st_in[i][31], st_in[i]} + START_BIAS;
      sb[i]     = (!s33[32] && s33[31]) ? {1'b0, DIST_MAX} : s33[31:0];
      mag_in[i] = dir_in[i][31] ? (~dir_in[i] + 32'd1) : dir_in[i];
    end
  end

  always_comb begin
    if (neg_r[ax_r]) begin
      f_init = {1'b0, frac_r[ax_r]};
    end else if (frac_r[ax_r] == 16'd0) begin
      f_init = '0;
    end else begin
      f_init = 17'h10000 - {1'b0, frac_r[ax_r]};
    end
    if (state_r == S_XMUL) begin
      mul_a = {15'd0, f_init};
      mul_b = {1'b0, stepd_r[ax_r]};
    end else begin
      mul_a = mag_r[ax_r];
      mul_b = mag_r[ax_r];
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  assign sq_t   = root_r + bit_r;
  assign sq_ge  = (acc_r >= sq_t);
  assign trial  = {div_rem_r, div_q_r[47]};
  assign div_ge = (trial >= {1'b0, mag_r[ax_r]});

  always_comb begin
    if (next_r[0] < next_r[1] && next_r[0] < next_r[2]) begin
      a_sel = 2'd0;
    end else if (next_r[1] < next_r[0] && next_r[1] < next_r[2]) begin
      a_sel = 2'd1;
    end else begin
      a_sel = 2'd2;
    end
    sum32 = {1'b0, next_r[a_sel]} + {1'b0, stepd_r[a_sel]};
    nadd  = sum32[31] ? DIST_MAX : sum32[30:0];
  end

  always_comb begin
    in_grid = !cell_r[0][CELL_W-1] && (cell_r[0][CELL_W-2:0] < (CELL_W-1)'(WORLD_SIDE))
           && !cell_r[1][CELL_W-1] && (cell_r[1][CELL_W-2:0] < (CELL_W-1)'(WORLD_HEIGHT))
           && !cell_r[2][CELL_W-1] && (cell_r[2][CELL_W-2:0] < (CELL_W-1)'(WORLD_SIDE));
    hit_v = in_grid ? ram_rdata : 8'd0;
    stop  = (hit_v != 8'd0) || (last_r >= range_r) || (cnt_r == STEP_W'(MAX_STEPS));
    ram_raddr = ADDR_W'(cell_r[0][CRD_W-1:0]) * ADDR_W'(WORLD_HEIGHT * WORLD_SIDE)
              + ADDR_W'(cell_r[1][CRD_W-1:0]) * ADDR_W'(WORLD_SIDE)
              + ADDR_W'(cell_r[2][CRD_W-1:0]);
  end

  always_comb begin
    wr_inside = (32'(in_item.voxel_x) < WORLD_SIDE) && (32'(in_item.voxel_y) < WORLD_HEIGHT)
             && (32'(in_item.voxel_z) < WORLD_SIDE);
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = (state_r == S_IDLE) && in_valid && (in_item.operation == OP_WRITE)
                && wr_inside;
      ram_waddr = ADDR_W'(in_item.voxel_x) * ADDR_W'(WORLD_HEIGHT * WORLD_SIDE)
                + ADDR_W'(in_item.voxel_y) * ADDR_W'(WORLD_SIDE)
                + ADDR_W'(in_item.voxel_z);
      ram_wdata = in_item.block_id;
    end
  end

  vrt_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_item.operation == OP_CAST) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i]  <= mag_in[i];
              neg_r[i]  <= dir_in[i][31];
              zero_r[i] <= (dir_in[i] == 32'd0);
              frac_r[i] <= sb[i][15:0];
              cell_r[i] <= CELL_W'($signed(sb[i][31:16]));
            end
            range_r <= in_item.range_limit;
            acc_r   <= '0;
            ax_r    <= 2'd0;
            state_r <= S_SQM;
          end
        end
        S_SQM: begin
          prod_r  <= mul_p;
          state_r <= S_SQA;
        end
        S_SQA: begin
          acc_r <= acc_r + prod_r;
          if (ax_r == 2'd2) begin
            root_r  <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            iter_r  <= 6'd31;
            state_r <= S_SQRT;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_SQM;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            acc_r  <= acc_r - sq_t;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          iter_r <= (iter_r == 6'd0) ? 6'd63 : iter_r - 6'd1;
          if (iter_r == 6'd0) begin
            ax_r    <= 2'd0;
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          if (iter_r == 6'd63) begin
            len_r <= root_r[31:0];
          end
          if (zero_r[ax_r]) begin
            stepd_r[ax_r] <= DIST_MAX;
            if (ax_r == 2'd2) begin
              ax_r    <= 2'd0;
              iter_r  <= 6'd0;
              state_r <= S_XMUL;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end else begin
            div_rem_r <= '0;
            div_q_r   <= {((iter_r == 6'd63) ? root_r[31:0] : len_r), 16'd0};
            iter_r    <= 6'd47;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_r <= div_ge ? 32'(trial - {1'b0, mag_r[ax_r]}) : trial[31:0];
          div_q_r   <= {div_q_r[46:0], div_ge};
          iter_r    <= (iter_r == 6'd0) ? 6'd63 : iter_r - 6'd1;
          if (iter_r == 6'd0) begin
            state_r <= S_XSAT;
            ax_r    <= ax_r;
          end
        end
        S_XMUL: begin
          prod_r  <= mul_p;
          state_r <= S_XSAT;
        end
        S_XSAT: begin
          if (iter_r == 6'd63 && !(zero_r[ax_r])) begin
            stepd_r[ax_r] <= (div_q_r[47:31] != 17'd0) ? DIST_MAX : div_q_r[30:0];
            if (ax_r == 2'd2) begin
              ax_r    <= 2'd0;
              iter_r  <= 6'd0;
              state_r <= S_XMUL;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_DINIT;
            end
          end else begin
            if (zero_r[ax_r]) begin
              next_r[ax_r] <= DIST_MAX;
            end else begin
              next_r[ax_r] <= (prod_r[63:47] != 17'd0) ? DIST_MAX : prod_r[46:16];
            end
            if (ax_r == 2'd2) begin
              for (int i = 0; i < 3; i++) begin
                prev_r[i] <= cell_r[i];
              end
              last_r  <= '0;
              cnt_r   <= '0;
              state_r <= S_RD;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_XMUL;
            end
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (stop) begin
            state_r <= S_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              prev_r[i] <= cell_r[i];
            end
            last_r        <= next_r[a_sel];
            next_r[a_sel] <= nadd;
            if (!zero_r[a_sel]) begin
              cell_r[a_sel] <= neg_r[a_sel] ? cell_r[a_sel] - CELL_W'(1)
                                            : cell_r[a_sel] + CELL_W'(1);
            end
            cnt_r   <= cnt_r + STEP_W'(1);
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_item_r.found_block  <= hit_v;
            out_item_r.hit_distance <= last_r;
            out_item_r.hit_x        <= cell_r[0][15:0];
            out_item_r.hit_y        <= cell_r[1][15:0];
            out_item_r.hit_z        <= cell_r[2][15:0];
            out_item_r.prev_x       <= prev_r[0][15:0];
            out_item_r.prev_y       <= prev_r[1][15:0];
            out_item_r.prev_z       <= prev_r[2][15:0];
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `include "voxel_ray_traversal_top_assert.svh"

  `VRT_ASSERT_IMP(a_we_idle, ram_we, state_r == S_CLR || state_r == S_IDLE, "write in cast")
  `VRT_ASSERT_IMP(a_step_bound, state_r == S_CHK, cnt_r <= STEP_W'(MAX_STEPS), "step limit")
  `VRT_ASSERT_NXT(a_res_src, !out_valid_r, !out_valid_r || $past(state_r) == S_DONE, "stray result")

endmodule

// File: tb/voxel_ray_traversal_top_tb.sv
// Self-checking testbench for voxel_ray_traversal_top: voxel writes and DDA ray casts.
// Depends on vrt_pkg; predicts each untyped cast result in place, checks all in order.
module voxel_ray_traversal_top_tb;
  import vrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int          DRAIN_CYCLES = 800;
  localparam int          PHASE_ITEMS = 400;

  typedef struct {
    vrt_in_t  item;
    bit       typed;
    vrt_out_t result;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vrt_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vrt_out_t out_item;

  bit [7:0]    grid_copy [STORE_DEPTH];
  vrt_out_t    pending_hits [$];
  stim_row_t   directed [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  voxel_ray_traversal_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic bit [7:0] voxel_at(int x, int y, int z);
    if (x < 0 || x >= WORLD_SIDE || y < 0 || y >= WORLD_HEIGHT || z < 0 || z >= WORLD_SIDE)
      return 8'd0;
    return grid_copy[(x * WORLD_HEIGHT + y) * WORLD_SIDE + z];
  endfunction

  function automatic vrt_out_t trace_ray(vrt_in_t it);
    longint signed   dv [3];
    longint signed   sv [3];
    longint unsigned mag [3];
    longint unsigned sum, rem, root, bitv, q, u, frac, f;
    int unsigned     stepd [3];
    int unsigned     nxt [3];
    int unsigned     last, len, rng;
    int              vox [3];
    int              sgn [3];
    int              prv [3];
    bit [7:0]        hit;
    int              a, i, n;
    vrt_out_t        r;
    dv[0] = longint'(it.dir_x);   dv[1] = longint'(it.dir_y);   dv[2] = longint'(it.dir_z);
    sv[0] = longint'(it.start_x); sv[1] = longint'(it.start_y); sv[2] = longint'(it.start_z);
    rng = 32'(it.range_limit);
    last = 0;
    sum = 0;
    for (i = 0; i < 3; i++) begin
      mag[i] = (dv[i] < 0) ? longint'(-dv[i]) : longint'(dv[i]);
      sum += mag[i] * mag[i];
    end
    rem = sum;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    len = root[31:0];
    for (i = 0; i < 3; i++) begin
      sv[i] += 7;
      if (sv[i] > 64'sd2147483647) sv[i] = 64'sd2147483647;
      u = sv[i] + 64'sd2147483648;
      frac = u & 64'hFFFF;
      vox[i] = int'(u >> 16) - 32768;
      if (mag[i] == 0) begin
        sgn[i] = 0;
        stepd[i] = 32'(DIST_MAX);
        nxt[i] = 32'(DIST_MAX);
      end else begin
        q = (longint'(len) << 16) / mag[i];
        stepd[i] = (q > DIST_MAX) ? 32'(DIST_MAX) : q[31:0];
        if (dv[i] > 0) begin
          sgn[i] = 1;
          f = (frac == 0) ? 64'd0 : 64'h10000 - frac;
        end else begin
          sgn[i] = -1;
          f = frac;
        end
        q = (f * stepd[i]) >> 16;
        nxt[i] = (q > DIST_MAX) ? 32'(DIST_MAX) : q[31:0];
      end
    end
    for (i = 0; i < 3; i++) prv[i] = vox[i];
    hit = voxel_at(vox[0], vox[1], vox[2]);
    for (n = 0; hit == 0 && last < rng && n < MAX_STEPS; n++) begin
      for (i = 0; i < 3; i++) prv[i] = vox[i];
      if (nxt[0] < nxt[1] && nxt[0] < nxt[2]) a = 0;
      else if (nxt[1] < nxt[0] && nxt[1] < nxt[2]) a = 1;
      else a = 2;
      last = nxt[a];
      q = longint'(nxt[a]) + stepd[a];
      nxt[a] = (q > DIST_MAX) ? 32'(DIST_MAX) : q[31:0];
      vox[a] += sgn[a];
      hit = voxel_at(vox[0], vox[1], vox[2]);
    end
    r.found_block = hit;
    r.hit_distance = last[30:0];
    r.hit_x = vox[0][15:0];
    r.hit_y = vox[1][15:0];
    r.hit_z = vox[2][15:0];
    r.prev_x = prv[0][15:0];
    r.prev_y = prv[1][15:0];
    r.prev_z = prv[2][15:0];
    return r;
  endfunction

  function automatic vrt_in_t write_item(int x, int y, int z, int id);
    vrt_in_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.voxel_x = 6'(x);
    it.voxel_y = 6'(y);
    it.voxel_z = 6'(z);
    it.block_id = 8'(id);
    return it;
  endfunction

  function automatic vrt_in_t cast_item(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                        logic [30:0] rng);
    vrt_in_t it;
    it = '0;
    it.operation = OP_CAST;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.dir_x = dx;   it.dir_y = dy;   it.dir_z = dz;
    it.range_limit = rng;
    return it;
  endfunction

  function automatic vrt_out_t hit_at(int blk, logic [30:0] dst, int x, int y, int z);
    vrt_out_t r;
    r.found_block = 8'(blk);
    r.hit_distance = dst;
    r.hit_x = 16'(x); r.hit_y = 16'(y); r.hit_z = 16'(z);
    r.prev_x = 16'(x); r.prev_y = 16'(y); r.prev_z = 16'(z);
    return r;
  endfunction

  function automatic logic [31:0] rand_dir();
    if ($urandom_range(0, 9) == 0) return 32'd0;
    return $signed($urandom) >>> $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] rand_start();
    return {16'($urandom_range(0, 31)), 16'($urandom_range(0, 65535))};
  endfunction

  function automatic vrt_in_t random_item();
    vrt_in_t     it;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(vrt_in_t)-1:0];
    if ($urandom_range(0, 4) == 0) return it;
    if ($urandom_range(0, 99) < 45) begin
      it.operation = OP_WRITE;
      it.voxel_x = 6'($urandom_range(4, 27));
      it.voxel_y = 6'($urandom_range(4, 27));
      it.voxel_z = 6'($urandom_range(4, 27));
      if ($urandom_range(0, 3) == 0) it.block_id = 8'd0;
    end else begin
      it.operation = OP_CAST;
      it.start_x = rand_start(); it.start_y = rand_start(); it.start_z = rand_start();
      it.dir_x = rand_dir(); it.dir_y = rand_dir(); it.dir_z = rand_dir();
      it.range_limit = ($urandom_range(0, 9) == 0) ? DIST_MAX
                                                   : 31'($urandom_range(0, 48 << 16));
    end
    return it;
  endfunction

  task automatic send_item(vrt_in_t it, bit typed, vrt_out_t result);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_WRITE) begin
      grid_copy[(int'(it.voxel_x) * WORLD_HEIGHT + it.voxel_y) * WORLD_SIDE + it.voxel_z] =
        it.block_id;
    end else begin
      pending_hits.push_back(typed ? result : trace_ray(it));
    end
  endtask

  always @(posedge clk) begin
    vrt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (out_item.found_block !== want.found_block) begin
          $error("found_block: expected %0d, got %0d", want.found_block, out_item.found_block);
          mismatches++;
        end
        if (out_item.hit_distance !== want.hit_distance) begin
          $error("hit_distance: expected %h, got %h", want.hit_distance, out_item.hit_distance);
          mismatches++;
        end
        if (out_item.hit_x !== want.hit_x) begin
          $error("hit_x: expected %0d, got %0d", want.hit_x, out_item.hit_x);
          mismatches++;
        end
        if (out_item.hit_y !== want.hit_y) begin
          $error("hit_y: expected %0d, got %0d", want.hit_y, out_item.hit_y);
          mismatches++;
        end
        if (out_item.hit_z !== want.hit_z) begin
          $error("hit_z: expected %0d, got %0d", want.hit_z, out_item.hit_z);
          mismatches++;
        end
        if (out_item.prev_x !== want.prev_x) begin
          $error("prev_x: expected %0d, got %0d", want.prev_x, out_item.prev_x);
          mismatches++;
        end
        if (out_item.prev_y !== want.prev_y) begin
          $error("prev_y: expected %0d, got %0d", want.prev_y, out_item.prev_y);
          mismatches++;
        end
        if (out_item.prev_z !== want.prev_z) begin
          $error("prev_z: expected %0d, got %0d", want.prev_z, out_item.prev_z);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    vrt_out_t  none;
    int        p, k;
    none = '0;
    directed.push_back('{cast_item(32'h18000, 32'h18000, 32'h18000, 32'h10000, 0, 0, 31'd0),
                         1, hit_at(0, 31'd0, 1, 1, 1)});
    directed.push_back('{cast_item(32'hA8000, 32'hA8000, 32'hA8000, 0, 0, 0, 31'd100 << 16),
                         1, hit_at(0, DIST_MAX, 10, 10, 10)});
    directed.push_back('{write_item(0, 0, 0, 255), 0, none});
    directed.push_back('{write_item(63, 63, 63, 1), 0, none});
    directed.push_back('{write_item(5, 5, 5, 0), 0, none});
    directed.push_back('{write_item(20, 10, 10, 42), 0, none});
    directed.push_back('{cast_item(32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, DIST_MAX),
                         1, hit_at(255, 31'd0, 0, 0, 0)});
    directed.push_back('{cast_item(32'hA8000, 32'hA8000, 32'hA8000, 32'h10000, 0, 0, DIST_MAX),
                         0, none});
    directed.push_back('{cast_item(32'h1E8000, 32'hA8000, 32'hA8000, 32'hFFFF0000, 0, 0,
                                   DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h28000, 32'h28000, 32'h28000, 32'h10000, 32'h10000,
                                   32'h10000, DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h80000000, 32'h7FFFFFFF, DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7FFFFFFF, 32'h80000000, DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h30000 - 7, 32'h30000 - 7, 32'h30000 - 7, 32'h8000, 0,
                                   32'hFFFF8000, 31'd40 << 16), 0, none});
    directed.push_back('{cast_item(32'hFFFA8000, 32'hA8000, 32'hA8000, 32'h10000, 0, 0,
                                   DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h3F8000, 32'h3F8000, 32'h3F0000, 0, 0, 32'h00001,
                                   DIST_MAX), 0, none});
    directed.push_back('{cast_item(32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 31'd0),
                         1, hit_at(255, 31'd0, 0, 0, 0)});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].result);
    for (p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 49 : (p == 3) ? 25 : 0;
      stall_pct = (p == 2) ? 49 : (p == 3) ? 25 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 0, none);
    end
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
